FILE: design/sstf_disk_request_scheduler_defines.svh
// ----------------------------------------------------------------------------
// SSTF disk request scheduler assertion macros
// Shared concurrent assertion forms, clocked by clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef SSTF_DISK_REQUEST_SCHEDULER_DEFINES_SVH
`define SSTF_DISK_REQUEST_SCHEDULER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSTF_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sstf scheduler assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SSTF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sstf scheduler assertion failed");

`endif

FILE: design/sstf_pkg.sv
// ----------------------------------------------------------------------------
// SSTF scheduler package
// Sizes, register indexes and status codes shared by the scheduler files.
// ----------------------------------------------------------------------------
package sstf_pkg;

    localparam int QUEUE_DEPTH    = 16;
    localparam int MAX_REQUESTERS = 16;
    localparam int TRACK_BITS     = 16;
    localparam int REQ_BITS       = 4;
    localparam int CFG_BITS       = 5;
    localparam int STATUS_BITS    = 2;

    localparam int SLOT_BITS  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS   = $clog2(QUEUE_DEPTH + 1);
    localparam int LIVE_BITS  = $clog2(MAX_REQUESTERS + 1);
    localparam int ENTRY_BITS = REQ_BITS + TRACK_BITS;

    typedef logic [STATUS_BITS-1:0] status_t;

    localparam status_t STATUS_ACCEPTED = 2'd0;
    localparam status_t STATUS_SERVED   = 2'd1;
    localparam status_t STATUS_BUSY     = 2'd2;
    localparam status_t STATUS_INVALID  = 2'd3;

    localparam logic REG_QUEUE_CAPACITY  = 1'b0;
    localparam logic REG_REQUESTER_COUNT = 1'b1;

    localparam logic MODE_SUBMIT = 1'b0;
    localparam logic MODE_FINISH = 1'b1;

endpackage

FILE: design/sstf_ram.sv
// ----------------------------------------------------------------------------
// SSTF generic RAM
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module sstf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/sstf_disk_request_scheduler.sv
// ----------------------------------------------------------------------------
// SSTF disk request scheduler
// Bounded request queue that services the entry nearest the head track.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to transfer one item; its single result
// appears for exactly one cycle with done high, and the receiver cannot
// stall it. Each item first walks the requester table to count live
// requesters, then decides; a result that services nothing follows the
// decision. When a request is serviced, the queued entries are then read
// one per cycle through the read port of the entry memory and compared
// against the head track. Busy drops in the cycle the result shows.
// ----------------------------------------------------------------------------
`include "sstf_disk_request_scheduler_defines.svh"

module sstf_disk_request_scheduler (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             mode,
    input  logic [sstf_pkg::REQ_BITS-1:0]    requester,
    input  logic [sstf_pkg::TRACK_BITS-1:0]  track,
    input  logic                             cfg_we,
    input  logic                             cfg_index,
    input  logic [sstf_pkg::CFG_BITS-1:0]    cfg_wdata,
    output logic                             done,
    output sstf_pkg::status_t                status,
    output logic [sstf_pkg::REQ_BITS-1:0]    served_requester,
    output logic [sstf_pkg::TRACK_BITS-1:0]  served_track,
    output logic                             all_done
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LIVE   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_SERVE  = 3'd4;

    localparam int QD  = sstf_pkg::QUEUE_DEPTH;
    localparam int MR  = sstf_pkg::MAX_REQUESTERS;
    localparam int SB  = sstf_pkg::SLOT_BITS;
    localparam int CB  = sstf_pkg::CNT_BITS;
    localparam int LB  = sstf_pkg::LIVE_BITS;
    localparam int RB  = sstf_pkg::REQ_BITS;
    localparam int TB  = sstf_pkg::TRACK_BITS;
    localparam int FB  = sstf_pkg::CFG_BITS;
    localparam int EB  = sstf_pkg::ENTRY_BITS;

    function automatic logic [CB-1:0] eff_cap_f(input logic [FB-1:0] cap,
                                                 input logic [LB-1:0] live);
        logic [CB-1:0] cap_sat;
        if (cap == '0)
        begin
            cap_sat = CB'(1);
        end
        else if (int'(cap) > QD)
        begin
            cap_sat = CB'(QD);
        end
        else
        begin
            cap_sat = CB'(cap);
        end
        if (int'(live) < int'(cap_sat))
        begin
            return CB'(live);
        end
        return cap_sat;
    endfunction

    // Control state.
    logic [2:0]          state_reg, state_next;
    logic [FB-1:0]       queue_capacity_reg, queue_capacity_next;
    logic [FB-1:0]       requester_count_reg, requester_count_next;
    logic [QD-1:0]       slot_valid_reg, slot_valid_next;
    logic [MR-1:0]       pending_reg, pending_next;
    logic [MR-1:0]       finished_reg, finished_next;
    logic [TB-1:0]       head_track_reg, head_track_next;
    logic [CB-1:0]       queue_count_reg, queue_count_next;
    logic [RB-1:0]       live_idx_reg, live_idx_next;
    logic [LB-1:0]       live_cnt_reg, live_cnt_next;
    logic [CB-1:0]       rd_idx_reg, rd_idx_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic                found_reg, found_next;
    logic                done_reg, done_next;

    // Payload.
    logic                mode_reg, mode_next;
    logic [RB-1:0]       who_reg, who_next;
    logic [TB-1:0]       track_reg, track_next;
    logic [SB-1:0]       cmp_idx_reg, cmp_idx_next;
    logic [SB-1:0]       best_slot_reg, best_slot_next;
    logic [RB-1:0]       best_who_reg, best_who_next;
    logic [TB-1:0]       best_track_reg, best_track_next;
    logic [TB-1:0]       best_dist_reg, best_dist_next;
    sstf_pkg::status_t   status_reg, status_next;
    logic [RB-1:0]       served_requester_reg, served_requester_next;
    logic [TB-1:0]       served_track_reg, served_track_next;
    logic                all_done_reg, all_done_next;

    // Decision and scan helpers.
    logic [LB-1:0]       participants;
    logic                free_found;
    logic [SB-1:0]       free_slot;
    logic [CB-1:0]       eff_cap;
    logic [CB-1:0]       count_after;
    logic [LB-1:0]       live_after;
    sstf_pkg::status_t   decide_status;
    logic                ram_we;
    logic [EB-1:0]       ram_rdata;
    logic [TB-1:0]       rd_track;
    logic [RB-1:0]       rd_who;
    logic [TB-1:0]       rd_dist;

    assign participants = (int'(requester_count_reg) > MR) ? LB'(MR)
                                                           : LB'(requester_count_reg);
    assign eff_cap = eff_cap_f(queue_capacity_reg, live_cnt_reg);
    assign rd_who   = ram_rdata[EB-1:TB];
    assign rd_track = ram_rdata[TB-1:0];
    assign rd_dist  = (rd_track >= head_track_reg) ? (rd_track - head_track_reg)
                                                   : (head_track_reg - rd_track);

    always_comb
    begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = QD - 1; i >= 0; i--)
        begin
            if (!slot_valid_reg[i])
            begin
                free_found = 1'b1;
                free_slot  = SB'(i);
            end
        end
    end

    sstf_ram #(
        .WIDTH (EB),
        .DEPTH (QD)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (free_slot),
        .wdata ({who_reg, track_reg}),
        .raddr (rd_idx_reg[SB-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next            = state_reg;
        queue_capacity_next   = queue_capacity_reg;
        requester_count_next  = requester_count_reg;
        slot_valid_next       = slot_valid_reg;
        pending_next          = pending_reg;
        finished_next         = finished_reg;
        head_track_next       = head_track_reg;
        queue_count_next      = queue_count_reg;
        live_idx_next         = live_idx_reg;
        live_cnt_next         = live_cnt_reg;
        rd_idx_next           = rd_idx_reg;
        cmp_vld_next          = 1'b0;
        found_next            = found_reg;
        done_next             = 1'b0;
        mode_next             = mode_reg;
        who_next              = who_reg;
        track_next            = track_reg;
        cmp_idx_next          = cmp_idx_reg;
        best_slot_next        = best_slot_reg;
        best_who_next         = best_who_reg;
        best_track_next       = best_track_reg;
        best_dist_next        = best_dist_reg;
        status_next           = status_reg;
        served_requester_next = served_requester_reg;
        served_track_next     = served_track_reg;
        all_done_next         = all_done_reg;
        ram_we                = 1'b0;
        count_after           = queue_count_reg;
        live_after            = live_cnt_reg;
        decide_status         = sstf_pkg::STATUS_ACCEPTED;

        if (cfg_we)
        begin
            unique case (cfg_index)
                sstf_pkg::REG_QUEUE_CAPACITY:  queue_capacity_next  = cfg_wdata;
                sstf_pkg::REG_REQUESTER_COUNT: requester_count_next = cfg_wdata;
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mode_next     = mode;
                    who_next      = requester;
                    track_next    = track;
                    live_idx_next = '0;
                    live_cnt_next = '0;
                    state_next    = S_LIVE;
                end
            end
            S_LIVE:
            begin
                if (LB'(live_idx_reg) < participants && !finished_reg[live_idx_reg])
                begin
                    live_cnt_next = live_cnt_reg + LB'(1);
                end
                if (live_idx_reg == RB'(MR - 1))
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    live_idx_next = live_idx_reg + RB'(1);
                end
            end
            S_DECIDE:
            begin
                if (!(LB'(who_reg) < participants) || finished_reg[who_reg])
                begin
                    decide_status = sstf_pkg::STATUS_INVALID;
                end
                else if (mode_reg == sstf_pkg::MODE_SUBMIT)
                begin
                    if (pending_reg[who_reg] || queue_count_reg >= eff_cap || !free_found)
                    begin
                        decide_status = sstf_pkg::STATUS_BUSY;
                    end
                    else
                    begin
                        ram_we                   = 1'b1;
                        slot_valid_next[free_slot] = 1'b1;
                        pending_next[who_reg]    = 1'b1;
                        count_after              = queue_count_reg + CB'(1);
                    end
                end
                else
                begin
                    finished_next[who_reg] = 1'b1;
                    live_after             = live_cnt_reg - LB'(1);
                end
                queue_count_next = count_after;
                live_cnt_next    = live_after;
                if (decide_status == sstf_pkg::STATUS_ACCEPTED && count_after != '0
                    && count_after >= eff_cap_f(queue_capacity_reg, live_after))
                begin
                    rd_idx_next = '0;
                    found_next  = 1'b0;
                    state_next  = S_SCAN;
                end
                else
                begin
                    status_next           = decide_status;
                    served_requester_next = '0;
                    served_track_next     = '0;
                    all_done_next         = (count_after == '0) && (live_after == '0);
                    done_next             = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (cmp_vld_reg && slot_valid_reg[cmp_idx_reg])
                begin
                    if (!found_reg || rd_dist < best_dist_reg)
                    begin
                        found_next      = 1'b1;
                        best_slot_next  = cmp_idx_reg;
                        best_who_next   = rd_who;
                        best_track_next = rd_track;
                        best_dist_next  = rd_dist;
                    end
                end
                if (rd_idx_reg < CB'(QD))
                begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = rd_idx_reg[SB-1:0];
                    rd_idx_next  = rd_idx_reg + CB'(1);
                end
                else
                begin
                    state_next = S_SERVE;
                end
            end
            S_SERVE:
            begin
                if (found_reg)
                begin
                    slot_valid_next[best_slot_reg] = 1'b0;
                    pending_next[best_who_reg]     = 1'b0;
                    queue_count_next               = queue_count_reg - CB'(1);
                    head_track_next                = best_track_reg;
                    status_next                    = sstf_pkg::STATUS_SERVED;
                    served_requester_next          = best_who_reg;
                    served_track_next              = best_track_reg;
                    all_done_next = (queue_count_reg == CB'(1)) && (live_cnt_reg == '0);
                end
                else
                begin
                    status_next           = sstf_pkg::STATUS_ACCEPTED;
                    served_requester_next = '0;
                    served_track_next     = '0;
                    all_done_next         = (queue_count_reg == '0) && (live_cnt_reg == '0);
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            queue_capacity_reg  <= FB'(QD);
            requester_count_reg <= FB'(MR);
            slot_valid_reg      <= '0;
            pending_reg         <= '0;
            finished_reg        <= '0;
            head_track_reg      <= '0;
            queue_count_reg     <= '0;
            live_idx_reg        <= '0;
            live_cnt_reg        <= '0;
            rd_idx_reg          <= '0;
            cmp_vld_reg         <= 1'b0;
            found_reg           <= 1'b0;
            done_reg            <= 1'b0;
        end
        else
        begin
            state_reg           <= state_next;
            queue_capacity_reg  <= queue_capacity_next;
            requester_count_reg <= requester_count_next;
            slot_valid_reg      <= slot_valid_next;
            pending_reg         <= pending_next;
            finished_reg        <= finished_next;
            head_track_reg      <= head_track_next;
            queue_count_reg     <= queue_count_next;
            live_idx_reg        <= live_idx_next;
            live_cnt_reg        <= live_cnt_next;
            rd_idx_reg          <= rd_idx_next;
            cmp_vld_reg         <= cmp_vld_next;
            found_reg           <= found_next;
            done_reg            <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg             <= mode_next;
        who_reg              <= who_next;
        track_reg            <= track_next;
        cmp_idx_reg          <= cmp_idx_next;
        best_slot_reg        <= best_slot_next;
        best_who_reg         <= best_who_next;
        best_track_reg       <= best_track_next;
        best_dist_reg        <= best_dist_next;
        status_reg           <= status_next;
        served_requester_reg <= served_requester_next;
        served_track_reg     <= served_track_next;
        all_done_reg         <= all_done_next;
    end

    assign busy             = (state_reg != S_IDLE);
    assign done             = done_reg;
    assign status           = status_reg;
    assign served_requester = served_requester_reg;
    assign served_track     = served_track_reg;
    assign all_done         = all_done_reg;

    `SSTF_ASSERT_IMPL(a_count_matches_valid, state_reg == S_IDLE, $countones(slot_valid_reg) == int'(queue_count_reg))
    `SSTF_ASSERT_NEXT(a_transfer_goes_busy, start && !busy, busy && !done)
    `SSTF_ASSERT_IMPL(a_unserved_result_zero, done && status != sstf_pkg::STATUS_SERVED, served_requester == '0 && served_track == '0)

endmodule

FILE: tb/sstf_disk_request_scheduler_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SSTF disk request scheduler checker
// Watches the command, result and register ports, keeps its own copy of the
// request queue and requester table, predicts the single result of each
// accepted transfer and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module sstf_disk_request_scheduler_checker
    import sstf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  logic                   mode,
    input  logic [REQ_BITS-1:0]    requester,
    input  logic [TRACK_BITS-1:0]  track,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [CFG_BITS-1:0]    cfg_wdata,
    input  logic                   done,
    input  status_t                status,
    input  logic [REQ_BITS-1:0]    served_requester,
    input  logic [TRACK_BITS-1:0]  served_track,
    input  logic                   all_done,
    output int                     fail_count,
    output int                     pending_results
);

    localparam int FIFO_DEPTH = 4;

    typedef struct packed {
        status_t                status;
        logic [REQ_BITS-1:0]    who;
        logic [TRACK_BITS-1:0]  trk;
        logic                   all_done;
    } outcome_t;

    outcome_t               expected_fifo [FIFO_DEPTH];
    int                     fifo_rd;
    int                     fifo_wr;
    int                     fifo_used;
    logic                   slot_used [QUEUE_DEPTH];
    logic [REQ_BITS-1:0]    slot_who  [QUEUE_DEPTH];
    logic [TRACK_BITS-1:0]  slot_trk  [QUEUE_DEPTH];
    logic                   queued_by [MAX_REQUESTERS];
    logic                   retired   [MAX_REQUESTERS];
    logic [TRACK_BITS-1:0]  head_pos;
    int                     queued_total;
    int                     capacity_reg;
    int                     requesters_reg;

    function automatic int participant_count();
        return (requesters_reg > MAX_REQUESTERS) ? MAX_REQUESTERS : requesters_reg;
    endfunction

    function automatic int seek_limit();
        int cap;
        int live;
        int i;
        cap = capacity_reg;
        live = 0;
        if (cap < 1)
            cap = 1;
        if (cap > QUEUE_DEPTH)
            cap = QUEUE_DEPTH;
        for (i = 0; i < participant_count(); i++)
            if (!retired[i])
                live++;
        return (live < cap) ? live : cap;
    endfunction

    function automatic logic everyone_retired();
        int i;
        if (queued_total != 0)
            return 1'b0;
        for (i = 0; i < participant_count(); i++)
            if (!retired[i])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic outcome_t schedule_item(logic m, logic [REQ_BITS-1:0] who,
                                               logic [TRACK_BITS-1:0] trk);
        outcome_t               r;
        int                     free_slot;
        int                     best;
        int                     i;
        logic [TRACK_BITS-1:0]  seek_len;
        logic [TRACK_BITS-1:0]  best_len;
        r = '0;
        r.status = STATUS_ACCEPTED;
        if (int'(who) >= participant_count() || retired[who])
        begin
            r.status = STATUS_INVALID;
        end
        else if (m == MODE_SUBMIT)
        begin
            if (queued_by[who] || queued_total >= seek_limit())
            begin
                r.status = STATUS_BUSY;
            end
            else
            begin
                free_slot = -1;
                for (i = 0; i < QUEUE_DEPTH; i++)
                    if (!slot_used[i] && free_slot < 0)
                        free_slot = i;
                if (free_slot < 0)
                begin
                    r.status = STATUS_BUSY;
                end
                else
                begin
                    slot_used[free_slot] = 1'b1;
                    slot_who[free_slot] = who;
                    slot_trk[free_slot] = trk;
                    queued_total++;
                    queued_by[who] = 1'b1;
                end
            end
        end
        else
        begin
            retired[who] = 1'b1;
        end

        // Nearest track to the head wins; on equal distance the lower slot keeps it.
        if (r.status == STATUS_ACCEPTED && queued_total > 0
            && queued_total >= seek_limit())
        begin
            best = -1;
            best_len = '0;
            for (i = 0; i < QUEUE_DEPTH; i++)
            begin
                if (slot_used[i])
                begin
                    seek_len = (slot_trk[i] >= head_pos) ? slot_trk[i] - head_pos
                                                         : head_pos - slot_trk[i];
                    if (best < 0 || seek_len < best_len)
                    begin
                        best = i;
                        best_len = seek_len;
                    end
                end
            end
            if (best >= 0)
            begin
                r.status = STATUS_SERVED;
                r.who = slot_who[best];
                r.trk = slot_trk[best];
                slot_used[best] = 1'b0;
                queued_total--;
                head_pos = slot_trk[best];
                queued_by[slot_who[best]] = 1'b0;
            end
        end
        r.all_done = everyone_retired();
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        outcome_t want;
        outcome_t fresh;
        int       i;
        if (!rst_n)
        begin
            for (i = 0; i < QUEUE_DEPTH; i++)
            begin
                slot_used[i] = 1'b0;
                slot_who[i] = '0;
                slot_trk[i] = '0;
            end
            for (i = 0; i < MAX_REQUESTERS; i++)
            begin
                queued_by[i] = 1'b0;
                retired[i] = 1'b0;
            end
            head_pos = '0;
            queued_total = 0;
            capacity_reg = 16;
            requesters_reg = 16;
            fifo_rd = 0;
            fifo_wr = 0;
            fifo_used = 0;
            fail_count = 0;
            pending_results = 0;
        end
        else
        begin
            if (done)
            begin
                if (fifo_used == 0)
                begin
                    $error("result seen with no transfer outstanding");
                    fail_count++;
                end
                else
                begin
                    want = expected_fifo[fifo_rd];
                    fifo_rd = (fifo_rd + 1) % FIFO_DEPTH;
                    fifo_used--;
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        fail_count++;
                    end
                    if (served_requester !== want.who)
                    begin
                        $error("served_requester: expected %0d, actual %0d",
                               want.who, served_requester);
                        fail_count++;
                    end
                    if (served_track !== want.trk)
                    begin
                        $error("served_track: expected %0h, actual %0h",
                               want.trk, served_track);
                        fail_count++;
                    end
                    if (all_done !== want.all_done)
                    begin
                        $error("all_done: expected %0d, actual %0d", want.all_done, all_done);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                fresh = schedule_item(mode, requester, track);
                if (fifo_used == FIFO_DEPTH)
                begin
                    $error("too many transfers outstanding");
                    fail_count++;
                end
                else
                begin
                    expected_fifo[fifo_wr] = fresh;
                    fifo_wr = (fifo_wr + 1) % FIFO_DEPTH;
                    fifo_used++;
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_QUEUE_CAPACITY)
                    capacity_reg = cfg_wdata;
                else
                    requesters_reg = cfg_wdata;
            end
            pending_results = fifo_used;
        end
    end

endmodule

FILE: tb/sstf_disk_request_scheduler_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SSTF disk request scheduler testbench
// Drives a directed run through the rejection and servicing cases, then
// several register settings with mostly well-formed random submits, some
// finishes and some noise, with random gaps; the checker judges every result.
// ----------------------------------------------------------------------------
module sstf_disk_request_scheduler_tb;
    import sstf_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic                   mode;
    logic [REQ_BITS-1:0]    requester;
    logic [TRACK_BITS-1:0]  track;
    logic                   cfg_we;
    logic                   cfg_index;
    logic [CFG_BITS-1:0]    cfg_wdata;
    logic                   done;
    status_t                status;
    logic [REQ_BITS-1:0]    served_requester;
    logic [TRACK_BITS-1:0]  served_track;
    logic                   all_done;
    int                     fail_count;
    int                     pending_results;

    int                     cycle_count = 0;
    int                     sent_count = 0;
    int                     part_now = 16;
    int                     finishes_left = 0;
    logic [MAX_REQUESTERS-1:0] retired_ids = '0;

    sstf_disk_request_scheduler dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .mode             (mode),
        .requester        (requester),
        .track            (track),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .done             (done),
        .status           (status),
        .served_requester (served_requester),
        .served_track     (served_track),
        .all_done         (all_done)
    );

    sstf_disk_request_scheduler_checker checker_inst (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .mode             (mode),
        .requester        (requester),
        .track            (track),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .done             (done),
        .status           (status),
        .served_requester (served_requester),
        .served_track     (served_track),
        .all_done         (all_done),
        .fail_count       (fail_count),
        .pending_results  (pending_results)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send(input logic m, input int who, input logic [TRACK_BITS-1:0] trk);
        int gap;
        gap = (((sent_count / 24) % 3) == 1) ? 0 : $urandom_range(0, 13);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        mode <= m;
        requester <= who[REQ_BITS-1:0];
        track <= trk;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (m == MODE_FINISH && who < part_now)
            retired_ids[who] = 1'b1;
        sent_count++;
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(negedge clk);
        while (pending_results != 0);
        @(posedge clk);
    endtask

    task automatic set_config(input int cap, input int count);
        cfg_we <= 1'b1;
        cfg_index <= REG_QUEUE_CAPACITY;
        cfg_wdata <= cap[CFG_BITS-1:0];
        @(posedge clk);
        cfg_index <= REG_REQUESTER_COUNT;
        cfg_wdata <= count[CFG_BITS-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        part_now = (count > MAX_REQUESTERS) ? MAX_REQUESTERS : count;
    endtask

    function automatic int live_id(input int k);
        int i;
        int seen;
        seen = 0;
        for (i = 0; i < part_now; i++)
        begin
            if (!retired_ids[i])
            begin
                if (seen == k)
                    return i;
                seen++;
            end
        end
        return 0;
    endfunction

    task automatic send_random();
        int                     roll;
        int                     pick;
        int                     who;
        int                     n_live;
        int                     i;
        logic [TRACK_BITS-1:0]  trk;
        roll = $urandom_range(0, 99);
        pick = $urandom_range(0, 19);
        if (pick == 0)
            trk = '0;
        else if (pick == 1)
            trk = '1;
        else if (pick < 7)
            trk = TRACK_BITS'($urandom_range(0, 15)) << 12;
        else
            trk = TRACK_BITS'($urandom);
        n_live = 0;
        for (i = 0; i < part_now; i++)
            if (!retired_ids[i])
                n_live++;

        if (roll < 6 && part_now < MAX_REQUESTERS)
        begin
            send(logic'($urandom_range(0, 1)), $urandom_range(part_now, MAX_REQUESTERS - 1), trk);
        end
        else if (roll < 10 && part_now > 0)
        begin
            who = $urandom_range(0, part_now - 1);
            if (retired_ids[who])
                send(logic'($urandom_range(0, 1)), who, trk);
            else
                send(MODE_SUBMIT, who, trk);
        end
        else if (roll < 13 && finishes_left > 0 && n_live > 3)
        begin
            finishes_left--;
            send(MODE_FINISH, live_id($urandom_range(0, n_live - 1)), trk);
        end
        else if (n_live > 0)
        begin
            send(MODE_SUBMIT, live_id($urandom_range(0, n_live - 1)), trk);
        end
        else
        begin
            send(logic'($urandom_range(0, 1)), $urandom_range(0, MAX_REQUESTERS - 1), trk);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        mode = MODE_SUBMIT;
        requester = '0;
        track = '0;
        cfg_we = 1'b0;
        cfg_index = REG_QUEUE_CAPACITY;
        cfg_wdata = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_config(2, 3);
        send(MODE_SUBMIT, 0, 16'h0000);
        send(MODE_SUBMIT, 0, 16'h1234);
        send(MODE_SUBMIT, 3, 16'hFFFF);
        send(MODE_SUBMIT, 15, 16'h5555);
        send(MODE_SUBMIT, 1, 16'hFFFF);
        send(MODE_SUBMIT, 2, 16'h8000);
        send(MODE_SUBMIT, 0, 16'h7000);
        drain();
        set_config(3, 3);
        // Two queued tracks sit at the same distance from the head here.
        send(MODE_SUBMIT, 0, 16'h6000);
        send(MODE_SUBMIT, 2, 16'h8000);
        drain();
        set_config(1, 3);
        send(MODE_SUBMIT, 0, 16'h0001);
        send(MODE_FINISH, 1, 16'hAAAA);
        send(MODE_FINISH, 1, 16'h0000);
        send(MODE_SUBMIT, 1, 16'h0000);
        send(MODE_FINISH, 0, 16'h0000);
        send(MODE_SUBMIT, 2, 16'h00FF);
        send(MODE_FINISH, 2, 16'hFFFF);
        send(MODE_SUBMIT, 2, 16'h0F0F);
        drain();
        set_config(0, 0);
        send(MODE_SUBMIT, 0, 16'h3C3C);
        drain();
        set_config(31, 31);
        send(MODE_SUBMIT, 15, 16'hFFFF);
        send(MODE_FINISH, 15, 16'h0000);
        send(MODE_SUBMIT, 3, 16'h0000);

        for (int phase = 0; phase < 7; phase++)
        begin
            drain();
            case (phase)
                0: set_config(1, 16);
                1: set_config(16, 8);
                2: set_config(0, 31);
                3: set_config(31, 12);
                4: set_config($urandom_range(2, 6), $urandom_range(4, 16));
                5: set_config($urandom_range(2, 16), $urandom_range(1, 31));
                default: set_config(3, 16);
            endcase
            finishes_left = 2;
            repeat (70)
            begin
                send_random();
                if ($urandom_range(0, 49) == 0)
                    drain();
            end
        end

        drain();
        repeat (40) @(posedge clk);
        if (fail_count == 0 && pending_results == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
